// ===== hdl/sha256_block_compress_core_macros.svh =====
// Assertion macros shared by the SHA-256 compression core.
// No dependencies; included by the files that carry assertions.
`ifndef SHA256_BLOCK_COMPRESS_CORE_MACROS_SVH
`define SHA256_BLOCK_COMPRESS_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sbc_pkg.sv =====
// Package for the SHA-256 compression core: sizes, payload types, commands,
// controller states and round constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbc_pkg;

	localparam int WORD_W     = 32;
	localparam int HASH_WORDS = 8;
	localparam int BLOCK_LEN  = 16;
	localparam int ROUNDS     = 64;
	localparam int SEL_W      = $clog2(HASH_WORDS);
	localparam int CNT_W      = $clog2(BLOCK_LEN);
	localparam int RND_W      = $clog2(ROUNDS);

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_MSG  = 1'b1
	} sbc_op_t;

	typedef struct packed {
		sbc_op_t             cmd;
		logic [SEL_W-1:0]    hash_select;
		logic [WORD_W-1:0]   data_word;
	} sbc_in_t;

	typedef struct packed {
		logic [SEL_W-1:0]    out_index;
		logic [WORD_W-1:0]   out_word;
		logic                last_word;
	} sbc_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} sbc_state_t;

	typedef struct packed {
		logic                load_chain;
		logic                shift_msg;
		logic                start;
		logic                round_en;
		logic [RND_W-1:0]    round_idx;
		logic                add_chain;
		logic [SEL_W-1:0]    emit_idx;
	} sbc_cmd_t;

	localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

`default_nettype wire

// ===== hdl/sha256_block_compress_core.sv =====
// SHA-256 compression core: a load transaction writes one chaining word; each
// message word transaction shifts one word into the message schedule. The
// sixteenth message word starts the block: 64 rounds at one round per cycle in
// the datapath, the chaining add, then eight result transactions, one per cycle
// while out_ready is high. in_ready is low after the sixteenth word until the
// last result is taken. The chaining value persists across blocks.
// Depends on sbc_pkg, sbc_ctrl and sbc_datapath.
`timescale 1ns / 1ps
`default_nettype none

module sha256_block_compress_core import sbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sbc_in_t   in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output sbc_out_t  out_data
);

	sbc_cmd_t          dp_cmd;
	logic [WORD_W-1:0] word;

	sbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_cmd    (in_data.cmd),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.dp_cmd    (dp_cmd)
	);

	sbc_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.dp_cmd   (dp_cmd),
		.in_data  (in_data),
		.out_word (word)
	);

	always_comb begin
		out_data.out_index = dp_cmd.emit_idx;
		out_data.out_word  = word;
		out_data.last_word = (dp_cmd.emit_idx == SEL_W'(HASH_WORDS - 1));
	end

endmodule

`default_nettype wire

// ===== hdl/sbc_ctrl.sv =====
// Controller of the SHA-256 compression core: message word count, round
// counter, result sequencing. Depends on sbc_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_block_compress_core_macros.svh"

module sbc_ctrl import sbc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  sbc_op_t          in_cmd,
	output logic             in_ready,
	input  logic             out_ready,
	output logic             out_valid,
	output sbc_cmd_t         dp_cmd
);

	localparam logic [CNT_W-1:0] LastMsg   = CNT_W'(BLOCK_LEN - 1);
	localparam logic [RND_W-1:0] LastRound = RND_W'(ROUNDS - 1);
	localparam logic [SEL_W-1:0] LastWord  = SEL_W'(HASH_WORDS - 1);

	sbc_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [RND_W-1:0]  rnd_q;
	logic [SEL_W-1:0]  idx_q;
	logic              in_acc, out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.shift_msg) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (dp_cmd.round_en) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (out_acc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT);
		in_acc    = in_valid && in_ready;
		out_acc   = out_valid && out_ready;

		dp_cmd.load_chain = in_acc && (in_cmd == CMD_LOAD);
		dp_cmd.shift_msg  = in_acc && (in_cmd == CMD_MSG);
		dp_cmd.start      = dp_cmd.shift_msg && (cnt_q == LastMsg);
		dp_cmd.round_en   = (state_q == ST_ROUND);
		dp_cmd.round_idx  = rnd_q;
		dp_cmd.add_chain  = (state_q == ST_ADD);
		dp_cmd.emit_idx   = idx_q;

		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (dp_cmd.start) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (rnd_q == LastRound) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_acc && (idx_q == LastWord)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`SBC_ASSERT_IMP(a_no_overlap, clk, arst_n, 1'b1, !(in_ready && out_valid), "input and output open together")
	`SBC_ASSERT_NXT(a_start_round, clk, arst_n, dp_cmd.start, (state_q == ST_ROUND) && (rnd_q == '0), "block did not start at round zero")
	`SBC_ASSERT_NXT(a_round_end, clk, arst_n, (state_q == ST_ROUND) && (rnd_q == LastRound), state_q == ST_ADD, "rounds did not end in the chaining add")
	`SBC_ASSERT_NXT(a_emit_end, clk, arst_n, out_acc && (idx_q == LastWord), (state_q == ST_IDLE) && (cnt_q == '0) && (idx_q == '0), "block did not close cleanly")

endmodule

`default_nettype wire

// ===== hdl/sbc_datapath.sv =====
// Datapath of the SHA-256 compression core: chaining words, message schedule
// shift line, working variables and the round logic. Depends on sbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbc_datapath import sbc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  sbc_cmd_t           dp_cmd,
	input  sbc_in_t            in_data,
	output logic [WORD_W-1:0]  out_word
);

	logic [WORD_W-1:0] chain_q [HASH_WORDS];
	logic [WORD_W-1:0] sched_q [BLOCK_LEN];
	logic [WORD_W-1:0] v_q     [HASH_WORDS];
	logic [WORD_W-1:0] w_new, t1, t2, ch, maj, sched_in;

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	always_comb begin
		w_new = sched_q[0]
			+ (rotr(sched_q[1], 7) ^ rotr(sched_q[1], 18) ^ (sched_q[1] >> 3))
			+ sched_q[9]
			+ (rotr(sched_q[14], 17) ^ rotr(sched_q[14], 19) ^ (sched_q[14] >> 10));
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1  = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ch + ROUND_K[dp_cmd.round_idx] + sched_q[0];
		t2  = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22)) + maj;
		sched_in = dp_cmd.shift_msg ? in_data.data_word : w_new;
		out_word = chain_q[dp_cmd.emit_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= '0;
			end
		end else if (dp_cmd.load_chain) begin
			chain_q[in_data.hash_select] <= in_data.data_word;
		end else if (dp_cmd.add_chain) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.shift_msg || dp_cmd.round_en) begin
			for (int i = 0; i < BLOCK_LEN - 1; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[BLOCK_LEN-1] <= sched_in;
		end
		if (dp_cmd.start) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (dp_cmd.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

`default_nettype wire
